### hw/rtl/ctq_pkg.sv
// Shared types and constants of the cancellable timer event queue.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package ctq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] ID_WRAP = 32'hFFFF_FFFF;

    // Request codes carried on the opcode field.
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_FLUSH  = 2'd3
    } t_op;

    // Result kinds.
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_FIRE   = 2'd2;

    // A classified request as it travels from the front to the back.
    typedef struct packed {
        t_op         op;
        logic [47:0] deadline;
        logic [31:0] event_id;
        logic [31:0] task_tag;
        logic [47:0] now_time;
    } t_cmd;

    // One result as it waits in the output queue.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [31:0] tag;
        logic        ok;
        logic        last;
    } t_result;

endpackage

### hw/rtl/cancellable_timer_event_queue_unit.sv
// Top level of the cancellable timer event queue: front, back and output queue.
// Depends on ctq_pkg, ctq_front, ctq_back and ctq_result_fifo.
//
// Channel   | Handshake            | Payload
// request   | push / full          | i_opcode, i_deadline, i_event_id, i_task_tag, i_now_time
// result    | empty / pop          | o_kind, o_id_out, o_tag_out, o_ok, o_last
// config    | i_cfg_we             | i_cfg_wdata (running)
//
// Add, cancel and flush are handled in the back end's idle state. A tick runs one scan
// per expired entry popped plus a final empty scan: the back end walks the 16 deadline
// slots one per cycle to find the earliest expired entry.
// Reset is synchronous and clears the slot marks, the id counter and both queues.
// The request queue holds two requests; the back end waits while the result queue
// is full.
`timescale 1ns / 1ps

module cancellable_timer_event_queue_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_opcode,
    input  logic [47:0] i_deadline,
    input  logic [31:0] i_event_id,
    input  logic [31:0] i_task_tag,
    input  logic [47:0] i_now_time,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [31:0] o_id_out,
    output logic [31:0] o_tag_out,
    output logic        o_ok,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);
    import ctq_pkg::*;

    logic    r_running;
    logic    w_valid;
    t_cmd    w_cmd;
    logic    w_take;
    logic    w_res_push;
    t_result w_res_in;
    logic    w_res_full;
    t_result w_res_out;

    // Running register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
        end else if (i_cfg_we) begin
            r_running <= i_cfg_wdata;
        end
    end

    ctq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_opcode   (i_opcode),
        .i_deadline (i_deadline),
        .i_event_id (i_event_id),
        .i_task_tag (i_task_tag),
        .i_now_time (i_now_time),
        .o_valid    (w_valid),
        .o_cmd      (w_cmd),
        .i_take     (w_take)
    );

    ctq_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_running  (r_running),
        .i_valid    (w_valid),
        .i_cmd      (w_cmd),
        .o_take     (w_take),
        .o_res_push (w_res_push),
        .o_res      (w_res_in),
        .i_res_full (w_res_full)
    );

    ctq_result_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res_in),
        .o_full  (w_res_full),
        .o_empty (empty),
        .o_res   (w_res_out),
        .i_pop   (pop)
    );

    assign o_kind    = w_res_out.kind;
    assign o_id_out  = w_res_out.id;
    assign o_tag_out = w_res_out.tag;
    assign o_ok      = w_res_out.ok;
    assign o_last    = w_res_out.last;

endmodule

### hw/rtl/ctq_front.sv
// Front end: a two-entry request queue that decodes the opcode of each request.
// Depends on ctq_pkg.
`timescale 1ns / 1ps

module ctq_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_opcode,
    input  logic [47:0]        i_deadline,
    input  logic [31:0]        i_event_id,
    input  logic [31:0]        i_task_tag,
    input  logic [47:0]        i_now_time,
    output logic               o_valid,
    output ctq_pkg::t_cmd      o_cmd,
    input  logic               i_take
);
    import ctq_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_in;

    // Classify the incoming request.
    always_comb begin
        w_in.op       = t_op'(i_opcode);
        w_in.deadline = i_deadline;
        w_in.event_id = i_event_id;
        w_in.task_tag = i_task_tag;
        w_in.now_time = i_now_time;
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= w_in;
    end

endmodule

### hw/rtl/ctq_back.sv
// Back end: holds the event slots and carries out add, cancel, tick and flush.
// Depends on ctq_pkg.
`timescale 1ns / 1ps

module ctq_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_running,
    input  logic               i_valid,
    input  ctq_pkg::t_cmd      i_cmd,
    output logic               o_take,
    output logic               o_res_push,
    output ctq_pkg::t_result   o_res,
    input  logic               i_res_full
);
    import ctq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [47:0]            r_dl    [QUEUE_DEPTH];
    logic [31:0]            r_ident [QUEUE_DEPTH];
    logic [31:0]            r_tag   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_used;
    logic [QUEUE_DEPTH-1:0] r_live;
    logic [31:0]            r_id_cnt;
    logic [47:0]            r_now;
    logic [SLOT_W-1:0]      r_idx;
    logic                   r_best_v;
    logic [SLOT_W-1:0]      r_best;
    logic [47:0]            r_best_dl;
    logic                   r_pend_v;
    t_result                r_pend;

    logic [31:0]            w_key;
    logic [QUEUE_DEPTH-1:0] w_match;
    logic                   w_free_v;
    logic [SLOT_W-1:0]      w_free;
    logic                   w_cand;
    logic                   w_fire_live;
    logic [31:0]            w_new_id;
    logic                   w_add_ok;
    logic [31:0]            w_add_id;

    // Id compare against every slot: the cancel id, or the id of the popped slot.
    assign w_key = (r_state == S_POP) ? r_ident[r_best] : i_cmd.event_id;
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_match[i] = r_used[i] && (r_ident[i] == w_key);
        end
    end

    // Lowest free slot.
    always_comb begin
        w_free_v = 1'b0;
        w_free   = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free_v = 1'b1;
                w_free   = SLOT_W'(i);
            end
        end
    end

    // Scan step: is the slot under the index an earlier expired entry?
    assign w_cand = r_used[r_idx] && (r_dl[r_idx] <= r_now)
                    && (!r_best_v || (r_dl[r_idx] < r_best_dl));

    assign w_fire_live = |(w_match & r_live);
    assign w_new_id    = (r_id_cnt == ID_WRAP) ? 32'd1 : r_id_cnt + 32'd1;
    assign w_add_ok    = i_running && w_free_v;
    assign w_add_id    = (w_add_ok && (i_cmd.event_id == 32'd0)) ? w_new_id
                                                                 : i_cmd.event_id;

    // Request take and result push.
    always_comb begin
        o_take     = 1'b0;
        o_res_push = 1'b0;
        o_res      = r_pend;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_cmd.op)
                        OP_ADD: begin
                            o_take     = !i_res_full;
                            o_res_push = !i_res_full;
                            o_res      = '{kind: KIND_ADD, id: w_add_id, tag: 32'd0,
                                           ok: w_add_ok, last: 1'b1};
                        end
                        OP_CANCEL: begin
                            o_take     = !i_res_full;
                            o_res_push = !i_res_full;
                            o_res      = '{kind: KIND_CANCEL, id: i_cmd.event_id,
                                           tag: 32'd0,
                                           ok: (i_cmd.event_id != 32'd0) && w_fire_live,
                                           last: 1'b1};
                        end
                        default: o_take = 1'b1;
                    endcase
                end
            end
            S_POP: begin
                o_res_push = !i_res_full && w_fire_live && r_pend_v;
            end
            S_DONE: begin
                o_res_push = r_pend_v && !i_res_full;
                o_res.last = 1'b1;
            end
            default: ;
        endcase
    end

    // Sequencer and slot state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_live   <= '0;
            r_id_cnt <= 32'd0;
            r_best_v <= 1'b0;
            r_pend_v <= 1'b0;
            r_idx    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        case (i_cmd.op)
                            OP_ADD: begin
                                if (!i_res_full && w_add_ok) begin
                                    if (i_cmd.event_id == 32'd0) r_id_cnt <= w_new_id;
                                    r_used[w_free]  <= 1'b1;
                                    r_live[w_free]  <= 1'b1;
                                    r_dl[w_free]    <= i_cmd.deadline;
                                    r_ident[w_free] <= w_add_id;
                                    r_tag[w_free]   <= i_cmd.task_tag;
                                end
                            end
                            OP_CANCEL: begin
                                if (!i_res_full && (i_cmd.event_id != 32'd0)) begin
                                    r_live <= r_live & ~w_match;
                                end
                            end
                            OP_TICK: begin
                                if (i_running) begin
                                    r_now    <= i_cmd.now_time;
                                    r_idx    <= '0;
                                    r_best_v <= 1'b0;
                                    r_pend_v <= 1'b0;
                                    r_state  <= S_SCAN;
                                end
                            end
                            default: begin
                                r_used <= '0;
                                r_live <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_cand) begin
                        r_best_v  <= 1'b1;
                        r_best    <= r_idx;
                        r_best_dl <= r_dl[r_idx];
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == SLOT_W'(QUEUE_DEPTH - 1)) begin
                        r_state <= (w_cand || r_best_v) ? S_POP : S_DONE;
                    end
                end
                S_POP: begin
                    if (!i_res_full) begin
                        if (w_fire_live) begin
                            r_pend_v <= 1'b1;
                            r_pend   <= '{kind: KIND_FIRE, id: r_ident[r_best],
                                          tag: r_tag[r_best], ok: 1'b1, last: 1'b0};
                        end
                        r_live         <= r_live & ~w_match & ~(QUEUE_DEPTH'(1) << r_best);
                        r_used[r_best] <= 1'b0;
                        r_idx          <= '0;
                        r_best_v       <= 1'b0;
                        r_state        <= S_SCAN;
                    end
                end
                S_DONE: begin
                    if (!r_pend_v || !i_res_full) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### hw/rtl/ctq_result_fifo.sv
// Output queue of four results between the back end and the result ports.
// Depends on ctq_pkg.
`timescale 1ns / 1ps

module ctq_result_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ctq_pkg::t_result   i_res,
    output logic               o_full,
    output logic               o_empty,
    output ctq_pkg::t_result   o_res,
    input  logic               i_pop
);
    import ctq_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 3'd4);
    assign o_empty = (r_count == 3'd0);
    assign o_res   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            if (w_push) r_wr <= r_wr + 2'd1;
            if (w_pop)  r_rd <= r_rd + 2'd1;
            r_count <= r_count + {2'b0, w_push} - {2'b0, w_pop};
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_res;
    end

endmodule

### hw/rtl/ctq_checker.sv
// Port-level checks of the cancellable timer event queue, bound to the top level.
// Depends on cancellable_timer_event_queue_unit and ctq_pkg.
`timescale 1ns / 1ps

module ctq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_kind,
    input logic [31:0] o_id_out,
    input logic [31:0] o_tag_out,
    input logic        o_ok,
    input logic        o_last
);
    import ctq_pkg::*;

    // After reset no result is waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

    // A stalled result holds its id, kind and last flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> ($stable(o_id_out) && $stable(o_kind) && $stable(o_last)))
        else $error("stalled result changed");

    // Replies end their request and carry no tag.
    a_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == KIND_ADD || o_kind == KIND_CANCEL))
        |-> (o_last && o_tag_out == 32'd0))
        else $error("malformed reply");

    // Fired events always report success.
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_FIRE) |-> o_ok)
        else $error("fired event without ok");

    // No unused result kind appears.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_kind == KIND_ADD || o_kind == KIND_CANCEL || o_kind == KIND_FIRE))
        else $error("unknown result kind");

endmodule

bind cancellable_timer_event_queue_unit ctq_checker u_ctq_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .empty     (empty),
    .pop       (pop),
    .o_kind    (o_kind),
    .o_id_out  (o_id_out),
    .o_tag_out (o_tag_out),
    .o_ok      (o_ok),
    .o_last    (o_last)
);
